// ===== hw/rtl/exrm_pkg.sv =====
`timescale 1ns / 1ps
package exrm_pkg;
	localparam int CsBits = 18;
	localparam int XyBits = 34;
	localparam int OutBits = 16;
	localparam int AngInBits = 16;
	localparam logic signed [15:0] PiQ13 = 16'sd25736;
	localparam logic signed [XyBits-1:0] GainQ30 = 34'sd652032874;
	localparam logic signed [35:0] PiQ30 = 36'sd3373259426;
	localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;

	typedef logic signed [CsBits-1:0] cs_t;

	typedef struct packed {
		logic signed [AngInBits-1:0] angle_x;
		logic signed [AngInBits-1:0] angle_y;
		logic signed [AngInBits-1:0] angle_z;
	} angles_t;

	typedef struct packed {
		logic signed [OutBits-1:0] m00;
		logic signed [OutBits-1:0] m01;
		logic signed [OutBits-1:0] m02;
		logic signed [OutBits-1:0] m10;
		logic signed [OutBits-1:0] m11;
		logic signed [OutBits-1:0] m12;
		logic signed [OutBits-1:0] m20;
		logic signed [OutBits-1:0] m21;
		logic signed [OutBits-1:0] m22;
	} matrix_t;

	function automatic logic signed [35:0] atan_q30(input int i);
		logic signed [35:0] r;
		case (i)
			0: r = 36'sd843314856;
			1: r = 36'sd497837829;
			2: r = 36'sd263043836;
			3: r = 36'sd133525158;
			4: r = 36'sd67021686;
			5: r = 36'sd33543515;
			6: r = 36'sd16775850;
			7: r = 36'sd8388437;
			8: r = 36'sd4194282;
			9: r = 36'sd2097149;
			10: r = 36'sd1048575;
			11: r = 36'sd524287;
			12: r = 36'sd262143;
			13: r = 36'sd131071;
			14: r = 36'sd65535;
			15: r = 36'sd32767;
			16: r = 36'sd16383;
			17: r = 36'sd8191;
			18: r = 36'sd4095;
			19: r = 36'sd2047;
			20: r = 36'sd1023;
			21: r = 36'sd511;
			22: r = 36'sd255;
			23: r = 36'sd127;
			24: r = 36'sd63;
			25: r = 36'sd31;
			26: r = 36'sd15;
			27: r = 36'sd8;
			28: r = 36'sd4;
			29: r = 36'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [35:0] q30_round(input logic signed [35:0] c, input int sh);
		logic signed [35:0] r;
		r = (c + (36'sd1 <<< (sh - 1))) >>> sh;
		return r;
	endfunction
endpackage

// ===== hw/rtl/exrm_stream_if.sv =====
`timescale 1ns / 1ps
interface exrm_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/euler_xyz_to_rotation_matrix_top.sv =====
`timescale 1ns / 1ps
// Euler XYZ angles to rotation matrix R = Rx(a) * Ry(b) * Rz(c).
// Input channel in_ch carries angle_x, angle_y, angle_z in signed Q3.13 radians;
// values beyond +-pi are clamped. Output channel out_ch carries m00..m22 in
// signed Q1.14, rounded and saturated to [-1, 1].
// One transfer is accepted every cycle while the pipe is not stalled. The stages are:
// fold, CORDIC_STEPS CORDIC stages, sine/cosine rounding, two product stages
// and the output rounding stage. Three CORDIC pipes run side by side.
// The whole pipeline advances as one: when the receiver holds ready low
// with a result waiting, every stage holds and in_ch.ready drops, so nothing
// is lost or repeated; bubbles travel down the pipe with their valid bits.
// Reset clears the valid bits only; the pipe is then empty and ready is high.
module euler_xyz_to_rotation_matrix_top #(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	exrm_stream_if.sink in_ch,
	exrm_stream_if.source out_ch
);
	localparam int Depth = CORDIC_STEPS + 5;

	logic [Depth-1:0] vld_q;
	logic adv;
	exrm_pkg::angles_t a;
	exrm_pkg::cs_t sa, ca, sb, cb, sc, cc;
	exrm_pkg::matrix_t m;

	assign a = in_ch.data;
	assign adv = !vld_q[Depth-1] || out_ch.ready;
	assign in_ch.ready = adv;
	assign out_ch.valid = vld_q[Depth-1];
	assign out_ch.data = m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[Depth-2:0], in_ch.valid};
	end

	exrm_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cx (
		.clk(clk), .adv(adv), .angle(a.angle_x), .sin_v(sa), .cos_v(ca));
	exrm_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cy (
		.clk(clk), .adv(adv), .angle(a.angle_y), .sin_v(sb), .cos_v(cb));
	exrm_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cz (
		.clk(clk), .adv(adv), .angle(a.angle_z), .sin_v(sc), .cos_v(cc));

	exrm_matrix u_mat (
		.clk(clk), .adv(adv), .sa(sa), .ca(ca), .sb(sb), .cb(cb), .sc(sc), .cc(cc),
		.m(m));

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(vld_q))
		else $error("pipeline moved during stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("ready low with empty output");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (m.m02 <= 16'sd16384) && (m.m02 >= -16'sd16384))
		else $error("m02 out of range");
endmodule

// ===== hw/rtl/exrm_cordic.sv =====
`timescale 1ns / 1ps
module exrm_cordic #(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic adv,
	input  logic signed [exrm_pkg::AngInBits-1:0] angle,
	output exrm_pkg::cs_t sin_v,
	output exrm_pkg::cs_t cos_v
);
	localparam int F = ANGLE_BITS - 3;
	localparam int Sh = 30 - F;
	localparam int ZW = ANGLE_BITS + 2;
	localparam int XW = exrm_pkg::XyBits;

	logic signed [ZW-1:0] z_s0;
	logic signed [ZW-1:0] hp, pi_c;
	logic signed [ZW-1:0] z_s [CORDIC_STEPS+1];
	logic signed [XW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [XW-1:0] y_s [CORDIC_STEPS+1];
	logic neg_s [CORDIC_STEPS+1];
	logic signed [15:0] a_cl;
	logic signed [XW-1:0] xr, yr;

	always_comb begin
		a_cl = angle;
		if (angle > exrm_pkg::PiQ13) a_cl = exrm_pkg::PiQ13;
		if (angle < -exrm_pkg::PiQ13) a_cl = -exrm_pkg::PiQ13;
		if (F >= 13) z_s0 = ZW'(signed'(a_cl)) <<< (F >= 13 ? F - 13 : 0);
		else z_s0 = ZW'(signed'(a_cl) >>> (F < 13 ? 13 - F : 0));
		hp = ZW'(exrm_pkg::q30_round(exrm_pkg::HalfPiQ30, Sh));
		pi_c = ZW'(exrm_pkg::q30_round(exrm_pkg::PiQ30, Sh));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s[0] <= (z_s0 > hp) || (z_s0 < -hp);
			if (z_s0 > hp) z_s[0] <= z_s0 - pi_c;
			else if (z_s0 < -hp) z_s[0] <= z_s0 + pi_c;
			else z_s[0] <= z_s0;
			x_s[0] <= exrm_pkg::GainQ30;
			y_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [ZW-1:0] T = ZW'(exrm_pkg::q30_round(exrm_pkg::atan_q30(i), Sh));
		always_ff @(posedge clk) begin
			if (adv) begin
				neg_s[i+1] <= neg_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - T;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + T;
				end
			end
		end
	end

	always_comb begin
		xr = neg_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
		yr = neg_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_v <= exrm_pkg::CsBits'((xr + (XW'(1) <<< 13)) >>> 14);
			sin_v <= exrm_pkg::CsBits'((yr + (XW'(1) <<< 13)) >>> 14);
		end
	end
endmodule

// ===== hw/rtl/exrm_matrix.sv =====
`timescale 1ns / 1ps
module exrm_matrix (
	input  logic clk,
	input  logic adv,
	input  exrm_pkg::cs_t sa,
	input  exrm_pkg::cs_t ca,
	input  exrm_pkg::cs_t sb,
	input  exrm_pkg::cs_t cb,
	input  exrm_pkg::cs_t sc,
	input  exrm_pkg::cs_t cc,
	output exrm_pkg::matrix_t m
);
	logic signed [35:0] cbcc_s1, cbsc_s1, sacb_s1, cacb_s1, sasb_s1, casb_s1;
	logic signed [35:0] casc_s1, cacc_s1, sasc_s1, sacc_s1;
	logic signed [17:0] sb_s1, cc_s1, sc_s1;
	logic signed [63:0] e_s2 [9];

	always_ff @(posedge clk) begin
		if (adv) begin
			cbcc_s1 <= cb * cc;
			cbsc_s1 <= cb * sc;
			sacb_s1 <= sa * cb;
			cacb_s1 <= ca * cb;
			sasb_s1 <= sa * sb;
			casb_s1 <= ca * sb;
			casc_s1 <= ca * sc;
			cacc_s1 <= ca * cc;
			sasc_s1 <= sa * sc;
			sacc_s1 <= sa * cc;
			sb_s1 <= sb;
			cc_s1 <= cc;
			sc_s1 <= sc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s2[0] <= 64'(cbcc_s1) <<< 16;
			e_s2[1] <= -(64'(cbsc_s1) <<< 16);
			e_s2[2] <= 64'(sb_s1) <<< 32;
			e_s2[3] <= (64'(casc_s1) <<< 16) + sasb_s1 * cc_s1;
			e_s2[4] <= (64'(cacc_s1) <<< 16) - sasb_s1 * sc_s1;
			e_s2[5] <= -(64'(sacb_s1) <<< 16);
			e_s2[6] <= (64'(sasc_s1) <<< 16) - casb_s1 * cc_s1;
			e_s2[7] <= (64'(sacc_s1) <<< 16) + casb_s1 * sc_s1;
			e_s2[8] <= 64'(cacb_s1) <<< 16;
		end
	end

	function automatic logic signed [15:0] sat(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = (v + (64'sd1 <<< 33)) >>> 34;
		if (r > 64'sd16384) r = 64'sd16384;
		if (r < -64'sd16384) r = -64'sd16384;
		return 16'(r);
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			m.m00 <= sat(e_s2[0]);
			m.m01 <= sat(e_s2[1]);
			m.m02 <= sat(e_s2[2]);
			m.m10 <= sat(e_s2[3]);
			m.m11 <= sat(e_s2[4]);
			m.m12 <= sat(e_s2[5]);
			m.m20 <= sat(e_s2[6]);
			m.m21 <= sat(e_s2[7]);
			m.m22 <= sat(e_s2[8]);
		end
	end
endmodule
